[design/lbfm_pkg.sv]
// lbfm_pkg: shared types and constants for the lru buffer frame manager
// used by lbfm_scan and lru_buffer_frame_manager; no dependencies
package lbfm_pkg;

	// fixed field widths of the request and response
	localparam int OP_W        = 2;
	localparam int BLK_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int FRAME_IDX_W = 5;

	// defaults for the top level parameters
	localparam int FRAME_COUNT_DEF      = 32;
	localparam int DISK_BLOCK_COUNT_DEF = 8192;
	localparam int AGE_BITS_DEF         = 16;

	// request kinds; the remaining code is ignored
	typedef enum logic [OP_W-1:0] {
		OP_ALLOC      = 2'd0,
		OP_LOOKUP     = 2'd1,
		OP_MARK_DIRTY = 2'd2
	} op_e;

	// response status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK   = 2'd0,
		STATUS_OOB  = 2'd1,
		STATUS_MISS = 2'd2
	} status_e;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [BLK_W-1:0] block_num;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [FRAME_IDX_W-1:0] frame_index;
		logic                   writeback_valid;
		logic [BLK_W-1:0]       writeback_block;
	} rsp_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic start;
		logic vld;
		logic alloc;
		logic occ;
	} scan_ctrl_t;

	// flags from the scan unit back to the sequencer
	typedef struct packed {
		logic free_found;
		logic hit;
	} scan_stat_t;

endpackage

[design/lru_buffer_frame_manager.sv]
// lru buffer frame manager: the result is set by one pass over the age and tag rams through
// the shared scan unit; the next request is taken only once the result has moved into the
// output register, which waits while rsp_stall holds a previous response.
// bad block and ignored requests skip the pass and load their result directly.
// reset clears the occupied and dirty bits at once; no clearing pass is needed.
// depends on lbfm_pkg, lbfm_ram, lbfm_scan
module lru_buffer_frame_manager #(
	parameter int FRAME_COUNT      = lbfm_pkg::FRAME_COUNT_DEF,
	parameter int DISK_BLOCK_COUNT = lbfm_pkg::DISK_BLOCK_COUNT_DEF,
	parameter int AGE_BITS         = lbfm_pkg::AGE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lbfm_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lbfm_pkg::rsp_t rsp
);
	import lbfm_pkg::*;

	localparam int IDX_W = $clog2(FRAME_COUNT);
	localparam int CNT_W = $clog2(FRAME_COUNT + 1);

	state_t                 state_q, state_d;
	logic [OP_W-1:0]        op_q;
	logic [BLK_W-1:0]       blk_q;
	logic [CNT_W-1:0]       issue_q;
	logic                   rd_vld_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic [FRAME_COUNT-1:0] occ_q;
	logic [FRAME_COUNT-1:0] dirty_q;
	rsp_t                   res_q, res_d;
	logic                   res_load;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                   accept;
	logic                   oob;
	logic                   issuing;
	logic                   scan_done;
	logic                   out_free;
	logic                   is_alloc;
	logic                   do_alloc;
	logic                   do_mark;
	logic [IDX_W-1:0]       sel_idx;
	logic                   victim_dirty;

	scan_ctrl_t             sctrl;
	scan_stat_t             sstat;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       best_idx;
	logic [BLK_W-1:0]       best_tag;
	logic [IDX_W-1:0]       hit_idx;
	logic                   scan_age_we;
	logic [AGE_BITS-1:0]    scan_age_wd;

	logic [AGE_BITS-1:0]    age_rd;
	logic [BLK_W-1:0]       tag_rd;
	logic                   age_we;
	logic [IDX_W-1:0]       age_wa;
	logic [AGE_BITS-1:0]    age_wd;

	// handshake and request decode
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign oob       = ({1'b0, req.block_num} >= (BLK_W + 1)'(DISK_BLOCK_COUNT));
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign is_alloc  = (op_q == OP_ALLOC);

	// scan read issue and completion
	assign issuing   = (state_q == S_SCAN) && (issue_q != CNT_W'(FRAME_COUNT));
	assign scan_done = rd_vld_s1 && (rd_idx_s1 == IDX_W'(FRAME_COUNT - 1));

	// victim choice after the pass
	assign sel_idx      = sstat.free_found ? free_idx : best_idx;
	assign victim_dirty = !sstat.free_found && dirty_q[best_idx];
	assign do_alloc     = (state_q == S_UPDATE) && is_alloc;
	assign do_mark      = (state_q == S_UPDATE) && (op_q == OP_MARK_DIRTY) && sstat.hit;

	// next state and result
	always_comb begin
		state_d  = state_q;
		res_d    = '0;
		res_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!(req.op inside {OP_ALLOC, OP_LOOKUP, OP_MARK_DIRTY})) begin
						res_load = 1'b1;
						state_d  = S_DONE;
					end else if (oob) begin
						res_d.status = STATUS_OOB;
						res_load     = 1'b1;
						state_d      = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				res_load = 1'b1;
				state_d  = S_DONE;
				if (is_alloc) begin
					res_d.status          = STATUS_OK;
					res_d.frame_index     = FRAME_IDX_W'(sel_idx);
					res_d.writeback_valid = victim_dirty;
					res_d.writeback_block = victim_dirty ? best_tag : '0;
				end else if (sstat.hit) begin
					res_d.status      = STATUS_OK;
					res_d.frame_index = FRAME_IDX_W'(hit_idx);
				end else begin
					res_d.status = STATUS_MISS;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (accept) begin
				issue_q <= '0;
			end else if (issuing) begin
				issue_q <= issue_q + CNT_W'(1);
			end
			rd_vld_s1 <= issuing;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.op;
			blk_q <= req.block_num;
		end
		rd_idx_s1 <= issue_q[IDX_W-1:0];
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// occupied and dirty bits per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			dirty_q <= '0;
		end else begin
			if (do_alloc) begin
				occ_q[sel_idx]   <= 1'b1;
				dirty_q[sel_idx] <= 1'b0;
			end
			if (do_mark) begin
				dirty_q[hit_idx] <= 1'b1;
			end
		end
	end

	// shared scan unit
	assign sctrl.start = accept;
	assign sctrl.vld   = rd_vld_s1;
	assign sctrl.alloc = is_alloc;
	assign sctrl.occ   = occ_q[rd_idx_s1];

	lbfm_scan #(
		.IDX_W    (IDX_W),
		.AGE_BITS (AGE_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sctrl),
		.idx      (rd_idx_s1),
		.age_rd   (age_rd),
		.tag_rd   (tag_rd),
		.blk      (blk_q),
		.age_we   (scan_age_we),
		.age_wd   (scan_age_wd),
		.stat     (sstat),
		.free_idx (free_idx),
		.best_idx (best_idx),
		.best_tag (best_tag),
		.hit_idx  (hit_idx)
	);

	// age ram write: aging during the pass, zero for the new frame
	assign age_we = scan_age_we || do_alloc;
	assign age_wa = do_alloc ? sel_idx : rd_idx_s1;
	assign age_wd = do_alloc ? '0 : scan_age_wd;

	lbfm_ram #(
		.WIDTH (AGE_BITS),
		.DEPTH (FRAME_COUNT)
	) u_age_ram (
		.clk     (clk),
		.wr_en   (age_we),
		.wr_addr (age_wa),
		.wr_data (age_wd),
		.rd_en   (issuing),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (age_rd)
	);

	lbfm_ram #(
		.WIDTH (BLK_W),
		.DEPTH (FRAME_COUNT)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (do_alloc),
		.wr_addr (sel_idx),
		.wr_data (blk_q),
		.rd_en   (issuing),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (tag_rd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= (state_q == S_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == S_DONE)) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[design/lbfm_ram.sv]
// lbfm_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module lbfm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/lbfm_scan.sv]
// lbfm_scan: shared per-frame unit, ages one frame and tracks free, oldest and match
// depends on lbfm_pkg
module lbfm_scan #(
	parameter int IDX_W    = 5,
	parameter int AGE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lbfm_pkg::scan_ctrl_t      ctrl,
	input  logic [IDX_W-1:0]          idx,
	input  logic [AGE_BITS-1:0]       age_rd,
	input  logic [lbfm_pkg::BLK_W-1:0] tag_rd,
	input  logic [lbfm_pkg::BLK_W-1:0] blk,
	output logic                      age_we,
	output logic [AGE_BITS-1:0]       age_wd,
	output lbfm_pkg::scan_stat_t      stat,
	output logic [IDX_W-1:0]          free_idx,
	output logic [IDX_W-1:0]          best_idx,
	output logic [lbfm_pkg::BLK_W-1:0] best_tag,
	output logic [IDX_W-1:0]          hit_idx
);
	import lbfm_pkg::*;

	logic                inc;
	logic [AGE_BITS-1:0] age_new;
	logic                take_best;
	logic                free_found_q;
	logic                hit_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [BLK_W-1:0]    best_tag_q;

	// saturating age increment of an occupied frame
	assign inc     = ctrl.occ && (age_rd != {AGE_BITS{1'b1}});
	assign age_wd  = age_rd + AGE_BITS'(1);
	assign age_new = inc ? age_wd : age_rd;
	assign age_we  = ctrl.vld && ctrl.alloc && inc;

	// oldest frame so far, ties keep the lower index
	assign take_best = ctrl.vld && ctrl.alloc && ctrl.occ &&
		((idx == '0) || (age_new > best_age_q));

	// tracking flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if (ctrl.start) begin
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if (ctrl.vld) begin
			if (!ctrl.occ) begin
				free_found_q <= 1'b1;
			end
			if (!ctrl.alloc && ctrl.occ && (tag_rd == blk)) begin
				hit_q <= 1'b1;
			end
		end
	end

	// tracked indices, ages and tags
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			best_age_q <= '0;
			best_idx_q <= '0;
		end else begin
			if (ctrl.vld && !ctrl.occ && !free_found_q) begin
				free_idx_q <= idx;
			end
			if (ctrl.vld && !ctrl.alloc && ctrl.occ && (tag_rd == blk) && !hit_q) begin
				hit_idx_q <= idx;
			end
			if (take_best) begin
				best_age_q <= age_new;
				best_idx_q <= idx;
				best_tag_q <= tag_rd;
			end
		end
	end

	assign stat.free_found = free_found_q;
	assign stat.hit        = hit_q;
	assign free_idx        = free_idx_q;
	assign best_idx        = best_idx_q;
	assign best_tag        = best_tag_q;
	assign hit_idx         = hit_idx_q;

endmodule
